FILE: sv/msd_pkg.sv
// Shared types, register map, reset values and the Morse code lookup for the symbol decoder.
package msd_pkg;

    localparam int CHAR_W    = 8;
    localparam int LETTER_W  = 7;
    localparam int PATTERN_W = 5;
    localparam int COUNT_W   = 3;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam logic [COUNT_W-1:0] MAX_SYMBOLS = 3'd5;

    localparam logic [1:0] REG_LONG_CHAR  = 2'd0;
    localparam logic [1:0] REG_SHORT_CHAR = 2'd1;
    localparam logic [1:0] REG_GAP_CHAR   = 2'd2;

    localparam logic [CHAR_W-1:0] LONG_CHAR_RESET  = 8'd95;
    localparam logic [CHAR_W-1:0] SHORT_CHAR_RESET = 8'd46;
    localparam logic [CHAR_W-1:0] GAP_CHAR_RESET   = 8'd32;

    localparam logic [LETTER_W-1:0] NO_MATCH = 7'd63;

    typedef struct packed {
        logic [CHAR_W-1:0] long_char;
        logic [CHAR_W-1:0] short_char;
        logic [CHAR_W-1:0] gap_char;
    } msd_cfg_t;

    typedef struct packed {
        logic                emit;
        logic [LETTER_W-1:0] letter;
    } msd_result_t;

    // bit i of pattern is set when symbol i is a dash
    function automatic logic [LETTER_W-1:0] decode_letter(
        input logic [COUNT_W-1:0]   count,
        input logic [PATTERN_W-1:0] pattern
    );
        logic [LETTER_W-1:0] letter;
        letter = NO_MATCH;
        case ({count, pattern})
            {3'd2, 5'b00010}: letter = 7'h41; // A
            {3'd4, 5'b00001}: letter = 7'h42; // B
            {3'd4, 5'b00101}: letter = 7'h43; // C
            {3'd3, 5'b00001}: letter = 7'h44; // D
            {3'd1, 5'b00000}: letter = 7'h45; // E
            {3'd4, 5'b00100}: letter = 7'h46; // F
            {3'd3, 5'b00011}: letter = 7'h47; // G
            {3'd4, 5'b00000}: letter = 7'h48; // H
            {3'd2, 5'b00000}: letter = 7'h49; // I
            {3'd4, 5'b01110}: letter = 7'h4A; // J
            {3'd3, 5'b00101}: letter = 7'h4B; // K
            {3'd4, 5'b00010}: letter = 7'h4C; // L
            {3'd2, 5'b00011}: letter = 7'h4D; // M
            {3'd2, 5'b00001}: letter = 7'h4E; // N
            {3'd3, 5'b00111}: letter = 7'h4F; // O
            {3'd4, 5'b00110}: letter = 7'h50; // P
            {3'd4, 5'b01011}: letter = 7'h51; // Q
            {3'd3, 5'b00010}: letter = 7'h52; // R
            {3'd3, 5'b00000}: letter = 7'h53; // S
            {3'd1, 5'b00001}: letter = 7'h54; // T
            {3'd3, 5'b00100}: letter = 7'h55; // U
            {3'd4, 5'b01000}: letter = 7'h56; // V
            {3'd3, 5'b00110}: letter = 7'h57; // W
            {3'd4, 5'b01001}: letter = 7'h58; // X
            {3'd4, 5'b01101}: letter = 7'h59; // Y
            {3'd4, 5'b00011}: letter = 7'h5A; // Z
            {3'd5, 5'b11111}: letter = 7'h30;
            {3'd5, 5'b11110}: letter = 7'h31;
            {3'd5, 5'b11100}: letter = 7'h32;
            {3'd5, 5'b11000}: letter = 7'h33;
            {3'd5, 5'b10000}: letter = 7'h34;
            {3'd5, 5'b00000}: letter = 7'h35;
            {3'd5, 5'b00001}: letter = 7'h36;
            {3'd5, 5'b00011}: letter = 7'h37;
            {3'd5, 5'b00111}: letter = 7'h38;
            {3'd5, 5'b01111}: letter = 7'h39;
            default:          letter = NO_MATCH;
        endcase
        return letter;
    endfunction

endpackage

FILE: sv/msd_cfg_regs.sv
// APB register block holding the long, short and gap characters.
module msd_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [msd_pkg::ADDR_W-1:0]    paddr,
    input  logic [msd_pkg::DATA_W-1:0]    pwdata,
    output logic [msd_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output msd_pkg::msd_cfg_t             cfg
);

    msd_pkg::msd_cfg_t  cfg_reg;
    msd_pkg::msd_cfg_t  cfg_next;
    logic [1:0]         reg_index;
    logic               wr_en;

    assign reg_index = paddr[3:2];
    assign wr_en     = psel & penable & pwrite;
    assign pready    = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_index)
                msd_pkg::REG_LONG_CHAR:  cfg_next.long_char  = pwdata[7:0];
                msd_pkg::REG_SHORT_CHAR: cfg_next.short_char = pwdata[7:0];
                msd_pkg::REG_GAP_CHAR:   cfg_next.gap_char   = pwdata[7:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            msd_pkg::REG_LONG_CHAR:  prdata = {24'd0, cfg_reg.long_char};
            msd_pkg::REG_SHORT_CHAR: prdata = {24'd0, cfg_reg.short_char};
            msd_pkg::REG_GAP_CHAR:   prdata = {24'd0, cfg_reg.gap_char};
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_char  <= msd_pkg::LONG_CHAR_RESET;
            cfg_reg.short_char <= msd_pkg::SHORT_CHAR_RESET;
            cfg_reg.gap_char   <= msd_pkg::GAP_CHAR_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: sv/msd_token_tracker.sv
// Token state (pattern, count, bad flag) and the per-character decode step.
module msd_token_tracker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  msd_pkg::msd_cfg_t             cfg,
    input  logic                          step,
    input  logic [msd_pkg::CHAR_W-1:0]    char_in,
    input  logic                          message_end,
    output msd_pkg::msd_result_t          result
);

    logic [msd_pkg::PATTERN_W-1:0] pattern_reg, pattern_next;
    logic [msd_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic                          bad_reg, bad_next;

    logic [msd_pkg::PATTERN_W-1:0] pattern_mid;
    logic [msd_pkg::COUNT_W-1:0]   count_mid;
    logic                          bad_mid;
    logic                          is_long, is_short, is_gap, is_symbol, is_foreign;
    logic                          close_tok;

    assign is_long    = (char_in == cfg.long_char);
    assign is_short   = !is_long && (char_in == cfg.short_char);
    assign is_gap     = !is_long && !is_short && (char_in == cfg.gap_char);
    assign is_symbol  = is_long || is_short;
    assign is_foreign = !is_symbol && !is_gap;

    always_comb begin
        pattern_mid = pattern_reg;
        count_mid   = count_reg;
        bad_mid     = bad_reg | is_foreign;
        if (is_symbol) begin
            if (count_reg >= msd_pkg::MAX_SYMBOLS) begin
                bad_mid = 1'b1;
            end else begin
                if (is_long) begin
                    pattern_mid = pattern_reg
                                | 5'(5'b00001 << count_reg);
                end
                count_mid = count_reg + 3'd1;
            end
        end
    end

    assign close_tok     = is_gap || message_end;
    assign result.emit   = close_tok && ((count_mid != '0) || bad_mid);
    assign result.letter = bad_mid ? msd_pkg::NO_MATCH
                                   : msd_pkg::decode_letter(count_mid, pattern_mid);

    always_comb begin
        if (close_tok) begin
            pattern_next = '0;
            count_next   = '0;
            bad_next     = 1'b0;
        end else begin
            pattern_next = pattern_mid;
            count_next   = count_mid;
            bad_next     = bad_mid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            count_reg   <= '0;
            bad_reg     <= 1'b0;
        end else if (step) begin
            pattern_reg <= pattern_next;
            count_reg   <= count_next;
            bad_reg     <= bad_next;
        end
    end

endmodule

FILE: sv/morse_symbol_decoder_unit.sv
// Top level of the Morse symbol decoder: input register, token tracker, result register.
// Takes one character per transaction and sustains one transaction per cycle while m_ready
// does not hold a pending letter back. A character is registered on acceptance and decoded
// against the token state once the result register is free, and a finished letter is
// registered and driven on m_letter. Dash, dot and gap characters are set over APB
// at byte addresses 0, 4 and 8 (reset '_', '.', ' '); write them only while idle.
// A gap or message_end closes a non-empty token and yields 'A'-'Z', '0'-'9', or '?'
// for tokens that are too long, hold foreign characters or match no code.
module morse_symbol_decoder_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [msd_pkg::ADDR_W-1:0]    paddr,
    input  logic [msd_pkg::DATA_W-1:0]    pwdata,
    output logic [msd_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [msd_pkg::CHAR_W-1:0]    s_char_in,
    input  logic                          s_message_end,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [msd_pkg::LETTER_W-1:0]  m_letter
);

    msd_pkg::msd_cfg_t             cfg;
    msd_pkg::msd_result_t          result;

    logic                          in_valid_reg, in_valid_next;
    logic [msd_pkg::CHAR_W-1:0]    char_reg;
    logic                          end_reg;
    logic                          out_valid_reg, out_valid_next;
    logic [msd_pkg::LETTER_W-1:0]  letter_reg;

    logic                          out_free;
    logic                          step;
    logic                          s_fire;

    msd_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    msd_token_tracker u_tracker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .step        (step),
        .char_in     (char_reg),
        .message_end (end_reg),
        .result      (result)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign step     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign s_fire   = s_valid && s_ready;

    assign m_valid  = out_valid_reg;
    assign m_letter = letter_reg;

    always_comb begin
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_comb begin
        if (step) begin
            out_valid_next = result.emit;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            char_reg <= s_char_in;
            end_reg  <= s_message_end;
        end
        if (step && result.emit) begin
            letter_reg <= result.letter;
        end
    end

endmodule

FILE: tb/tb_morse_symbol_decoder_unit.sv
// Self-checking testbench for the Morse symbol decoder: directed table, random phases, APB setup.
module tb_morse_symbol_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int SETTLE_CYCLES   = 6;
    localparam int PHASES          = 8;
    localparam int CHARS_PER_PHASE = 155;
    localparam int DIR_ROWS        = 26;

    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        LETTER_FROM_MODEL,
        LETTER_NONE,
        LETTER_GIVEN
    } letter_check_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_SPARSE
    } stall_mode_t;

    typedef struct packed {
        logic [msd_pkg::CHAR_W-1:0]   char_in;
        logic                         message_end;
        letter_check_t                check;
        logic [msd_pkg::LETTER_W-1:0] letter;
    } char_row_t;

    // reset marks: long '_', short '.', gap ' '
    localparam char_row_t DIRECTED_CHARS [DIR_ROWS] = '{
        '{msd_pkg::SHORT_CHAR_RESET, 1'b0, LETTER_FROM_MODEL, msd_pkg::NO_MATCH},
        '{msd_pkg::GAP_CHAR_RESET,   1'b1, LETTER_GIVEN,      7'h45}, // E, gap with message end
        '{msd_pkg::GAP_CHAR_RESET,   1'b0, LETTER_NONE,       msd_pkg::NO_MATCH}, // repeated gap
        '{msd_pkg::GAP_CHAR_RESET,   1'b1, LETTER_NONE,       msd_pkg::NO_MATCH}, // empty message
        '{msd_pkg::LONG_CHAR_RESET,  1'b1, LETTER_GIVEN,      7'h54},    // T
        '{msd_pkg::SHORT_CHAR_RESET, 1'b0, LETTER_FROM_MODEL, msd_pkg::NO_MATCH},
        '{msd_pkg::LONG_CHAR_RESET,  1'b0, LETTER_FROM_MODEL, msd_pkg::NO_MATCH},
        '{msd_pkg::GAP_CHAR_RESET,   1'b0, LETTER_GIVEN,      7'h41},    // A
        '{msd_pkg::LONG_CHAR_RESET,  1'b0, LETTER_FROM_MODEL, msd_pkg::NO_MATCH},
        '{msd_pkg::LONG_CHAR_RESET,  1'b0, LETTER_FROM_MODEL, msd_pkg::NO_MATCH},
        '{msd_pkg::LONG_CHAR_RESET,  1'b0, LETTER_FROM_MODEL, msd_pkg::NO_MATCH},
        '{msd_pkg::LONG_CHAR_RESET,  1'b0, LETTER_FROM_MODEL, msd_pkg::NO_MATCH},
        '{msd_pkg::LONG_CHAR_RESET,  1'b1, LETTER_GIVEN,      7'h30},    // 0
        '{msd_pkg::LONG_CHAR_RESET,  1'b0, LETTER_FROM_MODEL, msd_pkg::NO_MATCH},
        '{msd_pkg::LONG_CHAR_RESET,  1'b0, LETTER_FROM_MODEL, msd_pkg::NO_MATCH},
        '{msd_pkg::LONG_CHAR_RESET,  1'b0, LETTER_FROM_MODEL, msd_pkg::NO_MATCH},
        '{msd_pkg::LONG_CHAR_RESET,  1'b0, LETTER_FROM_MODEL, msd_pkg::NO_MATCH},
        '{msd_pkg::LONG_CHAR_RESET,  1'b0, LETTER_FROM_MODEL, msd_pkg::NO_MATCH},
        '{msd_pkg::LONG_CHAR_RESET,  1'b1, LETTER_GIVEN,      msd_pkg::NO_MATCH}, // overlong
        '{8'h00,                     1'b0, LETTER_FROM_MODEL, msd_pkg::NO_MATCH},
        '{8'hFF,                     1'b1, LETTER_GIVEN,      msd_pkg::NO_MATCH}, // foreign chars
        '{msd_pkg::SHORT_CHAR_RESET, 1'b0, LETTER_FROM_MODEL, msd_pkg::NO_MATCH},
        '{msd_pkg::SHORT_CHAR_RESET, 1'b0, LETTER_FROM_MODEL, msd_pkg::NO_MATCH},
        '{msd_pkg::LONG_CHAR_RESET,  1'b0, LETTER_FROM_MODEL, msd_pkg::NO_MATCH},
        '{msd_pkg::LONG_CHAR_RESET,  1'b0, LETTER_FROM_MODEL, msd_pkg::NO_MATCH},
        '{msd_pkg::GAP_CHAR_RESET,   1'b0, LETTER_FROM_MODEL, msd_pkg::NO_MATCH} // no matching code
    };

    logic                         aclk          = 1'b0;
    logic                         aresetn       = 1'b0;
    logic                         psel          = 1'b0;
    logic                         penable       = 1'b0;
    logic                         pwrite        = 1'b0;
    logic [msd_pkg::ADDR_W-1:0]   paddr         = '0;
    logic [msd_pkg::DATA_W-1:0]   pwdata        = '0;
    logic [msd_pkg::DATA_W-1:0]   prdata;
    logic                         pready;
    logic                         s_valid       = 1'b0;
    logic                         s_ready;
    logic [msd_pkg::CHAR_W-1:0]   s_char_in     = '0;
    logic                         s_message_end = 1'b0;
    logic                         m_valid;
    logic                         m_ready       = 1'b0;
    logic [msd_pkg::LETTER_W-1:0] m_letter;

    // travels with the payload so the monitor knows how the row is checked
    letter_check_t                row_check  = LETTER_FROM_MODEL;
    logic [msd_pkg::LETTER_W-1:0] row_letter = msd_pkg::NO_MATCH;

    msd_pkg::msd_cfg_t             marks;
    logic [msd_pkg::PATTERN_W-1:0] tok_pattern;
    logic [msd_pkg::COUNT_W-1:0]   tok_count;
    logic                          tok_bad;
    logic [msd_pkg::LETTER_W-1:0]  code_letter [0:255];

    logic [msd_pkg::LETTER_W-1:0]  expected_letters [$];
    int                            error_count  = 0;
    int                            chars_sent   = 0;
    int                            burst_left   = 0;
    int                            quiet_cycles = 0;
    msd_pkg::msd_cfg_t             phase_cfg [PHASES];

    stall_mode_t          stall_mode = STALL_NONE;
    int                   stall_left = 0;
    int                   stall_period = 2;

    morse_symbol_decoder_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_in     (s_char_in),
        .s_message_end (s_message_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_letter      (m_letter)
    );

    always #1 aclk = ~aclk;

    task automatic close_token(output bit emitted,
                               output logic [msd_pkg::LETTER_W-1:0] letter);
        emitted = 1'b0;
        letter  = msd_pkg::NO_MATCH;
        if (tok_count != '0 || tok_bad) begin
            emitted     = 1'b1;
            letter      = tok_bad ? msd_pkg::NO_MATCH : code_letter[{tok_count, tok_pattern}];
            tok_pattern = '0;
            tok_count   = '0;
            tok_bad     = 1'b0;
        end
    endtask

    // long, short, gap are matched in that order
    task automatic step_decoder(input logic [msd_pkg::CHAR_W-1:0] c, input logic last,
                                output bit emitted,
                                output logic [msd_pkg::LETTER_W-1:0] letter);
        emitted = 1'b0;
        letter  = msd_pkg::NO_MATCH;
        if (c == marks.long_char || c == marks.short_char) begin
            if (tok_count >= msd_pkg::MAX_SYMBOLS) begin
                tok_bad = 1'b1;
            end else begin
                tok_pattern[tok_count] = (c == marks.long_char);
                tok_count = tok_count + 3'd1;
            end
        end else if (c == marks.gap_char) begin
            close_token(emitted, letter);
        end else begin
            tok_bad = 1'b1;
        end
        if (last && !emitted) close_token(emitted, letter);
    endtask

    always @(posedge aclk) begin : result_monitor
        bit                           emitted;
        logic [msd_pkg::LETTER_W-1:0] letter_pred;
        logic [msd_pkg::LETTER_W-1:0] letter_exp;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                step_decoder(s_char_in, s_message_end, emitted, letter_pred);
                if (row_check == LETTER_GIVEN) begin
                    expected_letters.push_back(row_letter);
                end else if (row_check == LETTER_FROM_MODEL && emitted) begin
                    expected_letters.push_back(letter_pred);
                end
            end
            if (m_valid && m_ready) begin
                if (expected_letters.size() == 0) begin
                    $error("letter: expected none, actual %0d", m_letter);
                    error_count++;
                end else begin
                    letter_exp = expected_letters.pop_front();
                    if (m_letter !== letter_exp) begin
                        $error("letter: expected %0d, actual %0d", letter_exp, m_letter);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin : receiver
        if (stall_left == 0) begin
            stall_mode   = stall_mode_t'($urandom_range(0, 3));
            stall_left   = $urandom_range(20, 200);
            stall_period = $urandom_range(2, 8);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            STALL_NONE:     m_ready <= 1'b1;
            STALL_RANDOM:   m_ready <= ($urandom_range(0, 1) == 1);
            STALL_PERIODIC: m_ready <= ((stall_left % stall_period) == 0);
            default:        m_ready <= ($urandom_range(0, 15) != 0);
        endcase
    end

    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $error("no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_char(input logic [msd_pkg::CHAR_W-1:0] c, input logic last,
                             input letter_check_t check,
                             input logic [msd_pkg::LETTER_W-1:0] letter);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 48);
        end
        s_valid       <= 1'b1;
        s_char_in     <= c;
        s_message_end <= last;
        row_check     <= check;
        row_letter    <= letter;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        chars_sent++;
    endtask

    task automatic settle_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_letters.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [msd_pkg::DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            msd_pkg::REG_LONG_CHAR:  marks.long_char  = data[msd_pkg::CHAR_W-1:0];
            msd_pkg::REG_SHORT_CHAR: marks.short_char = data[msd_pkg::CHAR_W-1:0];
            msd_pkg::REG_GAP_CHAR:   marks.gap_char   = data[msd_pkg::CHAR_W-1:0];
            default:                 ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apb_read(input logic [1:0] idx);
        logic [msd_pkg::CHAR_W-1:0] want;
        case (idx)
            msd_pkg::REG_LONG_CHAR:  want = marks.long_char;
            msd_pkg::REG_SHORT_CHAR: want = marks.short_char;
            default:                 want = marks.gap_char;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata[msd_pkg::CHAR_W-1:0] !== want) begin
            $error("prdata[%0d]: expected %0d, actual %0d", idx, want,
                   prdata[msd_pkg::CHAR_W-1:0]);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // mostly well-formed tokens; overlong tokens, stray characters and gap runs mixed in
    task automatic random_stream(input int count);
        int                         stop_at;
        int                         kind;
        int                         len;
        int                         i;
        bit                         end_on_symbol;
        logic [msd_pkg::CHAR_W-1:0] sym;
        stop_at = chars_sent + count;
        while (chars_sent < stop_at) begin
            kind = $urandom_range(0, 99);
            if (kind < 80) begin
                len = (kind < 70) ? $urandom_range(1, 5) : $urandom_range(6, 8);
                end_on_symbol = ($urandom_range(0, 4) == 0);
                for (i = 0; i < len; i++) begin
                    sym = $urandom_range(0, 1) ? marks.long_char : marks.short_char;
                    if ($urandom_range(0, 19) == 0) sym = 8'($urandom_range(0, 255));
                    send_char(sym, end_on_symbol && (i == len - 1), LETTER_FROM_MODEL,
                              msd_pkg::NO_MATCH);
                end
                if (!end_on_symbol) begin
                    send_char(marks.gap_char, ($urandom_range(0, 7) == 0),
                              LETTER_FROM_MODEL, msd_pkg::NO_MATCH);
                end
            end else if (kind < 90) begin
                send_char(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0),
                          LETTER_FROM_MODEL, msd_pkg::NO_MATCH);
            end else begin
                len = $urandom_range(1, 3);
                for (i = 0; i < len; i++) begin
                    send_char(marks.gap_char, ($urandom_range(0, 5) == 0),
                              LETTER_FROM_MODEL, msd_pkg::NO_MATCH);
                end
            end
        end
    endtask

    initial begin : stimulus
        string                         codes;
        int                            k;
        int                            i;
        int                            p;
        logic [msd_pkg::COUNT_W-1:0]   cnt;
        logic [msd_pkg::PATTERN_W-1:0] pat;

        // codes for A-Z then 0-9, '_' long, '.' short; trailing space closes the last one
        codes = {"._ _... _._. _.. . .._. __. .... .. .___ _._ ._.. __ _. ___ .__. ",
                 "__._ ._. ... _ .._ ..._ .__ _.._ _.__ __.. _____ .____ ..___ ",
                 "...__ ...._ ..... _.... __... ___.. ____. "};
        for (i = 0; i < 256; i++) code_letter[i] = msd_pkg::NO_MATCH;
        k   = 0;
        cnt = '0;
        pat = '0;
        for (i = 0; i < codes.len(); i++) begin
            if (codes[i] == " ") begin
                code_letter[{cnt, pat}] = (k < 26) ? 7'(8'h41 + k) : 7'(8'h30 + k - 26);
                k++;
                cnt = '0;
                pat = '0;
            end else begin
                if (codes[i] == "_") pat[cnt] = 1'b1;
                cnt = cnt + 3'd1;
            end
        end

        marks.long_char  = msd_pkg::LONG_CHAR_RESET;
        marks.short_char = msd_pkg::SHORT_CHAR_RESET;
        marks.gap_char   = msd_pkg::GAP_CHAR_RESET;
        tok_pattern = '0;
        tok_count   = '0;
        tok_bad     = 1'b0;

        phase_cfg[0] = '{8'd0, 8'd255, 8'd128};
        phase_cfg[1] = '{8'd255, 8'd0, 8'd1};
        phase_cfg[2] = '{8'h55, 8'hAA, 8'h0F};
        phase_cfg[3] = '{8'd7, 8'd7, 8'd7};        // all roles equal, long wins
        phase_cfg[4] = '{8'd65, 8'd66, 8'd66};     // short hides gap
        phase_cfg[5] = '{8'd200, 8'd100, 8'd200};  // long hides gap
        phase_cfg[6] = '{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255))};
        phase_cfg[7] = '{msd_pkg::LONG_CHAR_RESET, msd_pkg::SHORT_CHAR_RESET,
                         msd_pkg::GAP_CHAR_RESET};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < DIR_ROWS; i++) begin
            send_char(DIRECTED_CHARS[i].char_in, DIRECTED_CHARS[i].message_end,
                      DIRECTED_CHARS[i].check, DIRECTED_CHARS[i].letter);
        end
        settle_idle();

        for (p = 0; p < PHASES; p++) begin
            apb_write(msd_pkg::REG_LONG_CHAR,  {24'($urandom), phase_cfg[p].long_char});
            apb_write(msd_pkg::REG_SHORT_CHAR, {24'($urandom), phase_cfg[p].short_char});
            apb_write(msd_pkg::REG_GAP_CHAR,   {24'($urandom), phase_cfg[p].gap_char});
            if (p % 3 == 0) apb_write(REG_UNUSED, $urandom);
            apb_read(msd_pkg::REG_LONG_CHAR);
            apb_read(msd_pkg::REG_SHORT_CHAR);
            apb_read(msd_pkg::REG_GAP_CHAR);
            random_stream(CHARS_PER_PHASE);
            settle_idle();
        end

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/msd_pkg.sv
sv/msd_cfg_regs.sv
sv/msd_token_tracker.sv
sv/morse_symbol_decoder_unit.sv
tb/tb_morse_symbol_decoder_unit.sv
